FILE: sv/vsi_pkg.sv
// ----------------------------------------------------------------------------
// vsi_pkg
// Types, constants and saturating helpers shared by the vortex sheet
// integrals unit and its testbench.
// ----------------------------------------------------------------------------
package vsi_pkg;

    localparam logic [1:0] KIND_NODE = 2'd0;
    localparam logic [1:0] KIND_SEG  = 2'd1;
    localparam logic [1:0] KIND_FIN  = 2'd2;

    localparam logic [1:0] REG_GAIN_ONE  = 2'd0;
    localparam logic [1:0] REG_GAIN_TWO  = 2'd1;
    localparam logic [1:0] REG_SMOOTHING = 2'd2;

    localparam logic [63:0] PI_Q60     = 64'h3243F6A8885A308D;
    localparam logic [63:0] TWO_PI_Q60 = 64'h6487ED5110B4611A;
    localparam logic [63:0] S64_MAX    = 64'h7FFFFFFFFFFFFFFF;
    localparam logic [63:0] S64_MIN    = 64'h8000000000000000;

    typedef struct packed {
        logic [1:0]         kind;
        logic signed [31:0] node_strength;
        logic signed [31:0] node_weight;
        logic signed [31:0] node_radius;
        logic signed [31:0] start_radius;
        logic signed [31:0] start_height;
        logic signed [31:0] end_radius;
        logic signed [31:0] end_height;
        logic [3:0]         layer_count;
        logic               is_interfacial;
        logic signed [31:0] top_axis_height;
        logic signed [31:0] bottom_axis_height;
    } in_word_t;

    typedef struct packed {
        logic [31:0]        step_number;
        logic signed [63:0] sim_time;
        logic signed [63:0] next_step_size;
        logic signed [63:0] param_length;
        logic signed [63:0] phys_length;
        logic signed [63:0] circ_total;
        logic signed [63:0] impulse_total;
        logic signed [63:0] volume_total;
        logic signed [63:0] thickness;
        logic               saturated;
    } out_word_t;

    function automatic logic [63:0] mag64(input logic [63:0] a);
        return a[63] ? (64'd0 - a) : a;
    endfunction

    // magnitude plus sign to signed 64, {flag, value}
    function automatic logic [64:0] sat_mag(input logic [127:0] m, input logic neg);
        logic [63:0] lim;
        lim = neg ? S64_MIN : S64_MAX;
        if (m[127:64] != 64'd0 || m[63:0] > lim) begin
            return {1'b1, lim};
        end
        return {1'b0, neg ? (64'd0 - m[63:0]) : m[63:0]};
    endfunction

    function automatic logic [64:0] add_sat(input logic [63:0] a, input logic [63:0] b);
        logic [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            return {1'b1, a[63] ? S64_MIN : S64_MAX};
        end
        return {1'b0, s};
    endfunction

endpackage

FILE: sv/vsi_mul.sv
// ----------------------------------------------------------------------------
// vsi_mul
// Shared 64 x 64 unsigned multiplier, one 32 x 32 partial product a cycle.
// ----------------------------------------------------------------------------
module vsi_mul (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic [63:0]  op_a,
    input  logic [63:0]  op_b,
    output logic         done,
    output logic [127:0] prod
);
    logic [63:0]  a_reg, a_next, b_reg, b_next;
    logic [2:0]   cnt_reg, cnt_next;
    logic         busy_reg, busy_next, done_reg, done_next;
    logic         ppv_reg, ppv_next;
    logic [63:0]  pp_reg, pp_next;
    logic [1:0]   pos_reg, pos_next;
    logic [127:0] acc_reg, acc_next;
    logic [31:0]  a_half, b_half;

    assign a_half = cnt_reg[1] ? a_reg[63:32] : a_reg[31:0];
    assign b_half = cnt_reg[0] ? b_reg[63:32] : b_reg[31:0];

    always_comb begin
        a_next    = a_reg;
        b_next    = b_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        ppv_next  = 1'b0;
        pp_next   = pp_reg;
        pos_next  = pos_reg;
        acc_next  = acc_reg;
        if (ppv_reg) begin
            case (pos_reg)
                2'd0:    acc_next = acc_reg + {64'd0, pp_reg};
                2'd1:    acc_next = acc_reg + {32'd0, pp_reg, 32'd0};
                default: acc_next = acc_reg + {pp_reg, 64'd0};
            endcase
        end
        if (start) begin
            a_next    = op_a;
            b_next    = op_b;
            cnt_next  = 3'd0;
            busy_next = 1'b1;
            acc_next  = '0;
        end else if (busy_reg) begin
            if (cnt_reg == 3'd4) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end else begin
                pp_next  = a_half * b_half;
                pos_next = {cnt_reg[1] & cnt_reg[0], cnt_reg[1] ^ cnt_reg[0]};
                ppv_next = 1'b1;
                cnt_next = cnt_reg + 3'd1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            ppv_reg  <= 1'b0;
            cnt_reg  <= 3'd0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            ppv_reg  <= ppv_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        a_reg   <= a_next;
        b_reg   <= b_next;
        pp_reg  <= pp_next;
        pos_reg <= pos_next;
        acc_reg <= acc_next;
    end

    assign done = done_reg;
    assign prod = acc_reg;
endmodule

FILE: sv/vsi_shsub.sv
// ----------------------------------------------------------------------------
// vsi_shsub
// Shared shift and subtract unit: 128 / 64 restoring divide, one quotient bit
// a cycle, or floor square root of 128 bits, one root bit a cycle.
// ----------------------------------------------------------------------------
module vsi_shsub (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         start,
    input  logic         sqrt_mode,
    input  logic [127:0] num,
    input  logic [63:0]  den,
    output logic         done,
    output logic [127:0] result
);
    logic         busy_reg, busy_next, done_reg, done_next;
    logic         mode_reg, mode_next;
    logic [6:0]   cnt_reg, cnt_next;
    logic [127:0] num_reg, num_next;
    logic [63:0]  den_reg, den_next;
    logic [65:0]  rem_reg, rem_next;
    logic [63:0]  root_reg, root_next;
    logic [64:0]  div_t;
    logic         div_ge;
    logic [67:0]  sq_t, sq_trial;
    logic         sq_ge;

    assign div_t    = {rem_reg[63:0], num_reg[127]};
    assign div_ge   = div_t >= {1'b0, den_reg};
    assign sq_t     = {rem_reg, num_reg[127:126]};
    assign sq_trial = {2'b00, root_reg, 2'b01};
    assign sq_ge    = sq_t >= sq_trial;

    always_comb begin
        busy_next = busy_reg;
        done_next = 1'b0;
        mode_next = mode_reg;
        cnt_next  = cnt_reg;
        num_next  = num_reg;
        den_next  = den_reg;
        rem_next  = rem_reg;
        root_next = root_reg;
        if (start) begin
            busy_next = 1'b1;
            mode_next = sqrt_mode;
            cnt_next  = sqrt_mode ? 7'd63 : 7'd127;
            num_next  = num;
            den_next  = den;
            rem_next  = '0;
            root_next = '0;
        end else if (busy_reg) begin
            if (mode_reg) begin
                rem_next  = sq_ge ? 66'(sq_t - sq_trial) : sq_t[65:0];
                root_next = {root_reg[62:0], sq_ge};
                num_next  = {num_reg[125:0], 2'b00};
            end else begin
                rem_next = {1'b0, div_ge ? (div_t - {1'b0, den_reg}) : div_t};
                num_next = {num_reg[126:0], div_ge};
            end
            cnt_next = cnt_reg - 7'd1;
            if (cnt_reg == 7'd0) begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end else begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        mode_reg <= mode_next;
        cnt_reg  <= cnt_next;
        num_reg  <= num_next;
        den_reg  <= den_next;
        rem_reg  <= rem_next;
        root_reg <= root_next;
    end

    assign done   = done_reg;
    assign result = mode_reg ? {64'd0, root_reg} : num_reg;
endmodule

FILE: sv/vortex_sheet_integrals_unit.sv
// ----------------------------------------------------------------------------
// vortex_sheet_integrals_unit
// Integral diagnostics of an axisymmetric vortex sheet, one item at a time.
// ----------------------------------------------------------------------------
// Node words add weight, circulation and impulse; segment words add physical
// length and, when interfacial, volume; a finish word advances time, counts the
// step, works out the next step size and sends one result word, after which
// the five sums and the saturation flag clear. One item is in work at a time
// and s_ready is high only while the unit is idle. Each multiply runs in the
// shared 64 x 64 multiplier (four 32 x 32 partial products); the shift and
// subtract unit gives a root (64 root bits) or a quotient (128 quotient bits).
// A finish word runs up to two divides, skipping the first at zero thickness
// and the second at zero circulation, and may also wait on m_ready.
// ----------------------------------------------------------------------------
module vortex_sheet_integrals_unit #(
    parameter int FRAC_BITS = 16
) (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    output logic               s_ready,
    input  vsi_pkg::in_word_t  s_data,
    output logic               m_valid,
    input  logic               m_ready,
    output vsi_pkg::out_word_t m_data,
    input  logic               cfg_valid,
    output logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data
);
    import vsi_pkg::*;

    localparam int SH2 = 2 * FRAC_BITS;

    localparam logic [4:0] ST_IDLE   = 5'd0;
    localparam logic [4:0] ST_N_GW   = 5'd1;
    localparam logic [4:0] ST_N_RR   = 5'd2;
    localparam logic [4:0] ST_N_IMP  = 5'd3;
    localparam logic [4:0] ST_S_R2   = 5'd4;
    localparam logic [4:0] ST_S_Z2   = 5'd5;
    localparam logic [4:0] ST_S_SQ   = 5'd6;
    localparam logic [4:0] ST_S_LEN  = 5'd7;
    localparam logic [4:0] ST_S_RM   = 5'd8;
    localparam logic [4:0] ST_S_VOL  = 5'd9;
    localparam logic [4:0] ST_F_IMP  = 5'd10;
    localparam logic [4:0] ST_F_VOL  = 5'd11;
    localparam logic [4:0] ST_F_M1   = 5'd12;
    localparam logic [4:0] ST_F_D1   = 5'd13;
    localparam logic [4:0] ST_F_M2   = 5'd14;
    localparam logic [4:0] ST_F_D2   = 5'd15;
    localparam logic [4:0] ST_F_EMIT = 5'd16;

    logic [4:0]   state_reg, state_next;
    in_word_t     item_reg, item_next;
    logic [30:0]  gain1_reg, gain1_next, gain2_reg, gain2_next, smooth_reg, smooth_next;
    logic [63:0]  param_reg, param_next, phys_reg, phys_next, circ_reg, circ_next;
    logic [63:0]  imp_reg, imp_next, vol_reg, vol_next;
    logic [31:0]  step_cnt_reg, step_cnt_next;
    logic [63:0]  time_reg, time_next, step_reg, step_next;
    logic         sat_reg, sat_next;
    logic [63:0]  tmp_reg, tmp_next, dt1_reg, dt1_next;
    logic [63:0]  imp_out_reg, imp_out_next, vol_out_reg, vol_out_next;
    logic         mul_start_reg, mul_start_next;
    logic [63:0]  mul_a_reg, mul_a_next, mul_b_reg, mul_b_next;
    logic         ss_start_reg, ss_start_next, ss_sqrt_reg, ss_sqrt_next;
    logic [127:0] ss_num_reg, ss_num_next;
    logic [63:0]  ss_den_reg, ss_den_next;
    out_word_t    out_reg, out_next;
    logic         m_valid_reg, m_valid_next;

    logic         mul_done, ss_done;
    logic [127:0] mul_prod, ss_result;

    in_word_t     src;
    logic [63:0]  g64, w64, r64, dr, dz, s_sum, tq, acirc, dtn;
    logic [64:0]  sum65, res_a, res_b, res_c;

    vsi_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start_reg),
        .op_a    (mul_a_reg),
        .op_b    (mul_b_reg),
        .done    (mul_done),
        .prod    (mul_prod)
    );

    vsi_shsub u_shsub (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .start     (ss_start_reg),
        .sqrt_mode (ss_sqrt_reg),
        .num       (ss_num_reg),
        .den       (ss_den_reg),
        .done      (ss_done),
        .result    (ss_result)
    );

    // the idle state looks at the incoming word, the rest at the held one
    assign src   = (state_reg == ST_IDLE) ? s_data : item_reg;
    assign g64   = {{32{src.node_strength[31]}}, src.node_strength};
    assign w64   = {{32{src.node_weight[31]}}, src.node_weight};
    assign r64   = {{32{src.node_radius[31]}}, src.node_radius};
    assign dr    = {{32{src.end_radius[31]}}, src.end_radius}
                 - {{32{src.start_radius[31]}}, src.start_radius};
    assign dz    = {{32{src.end_height[31]}}, src.end_height}
                 - {{32{src.start_height[31]}}, src.start_height};
    assign s_sum = {{32{src.end_radius[31]}}, src.end_radius}
                 + {{32{src.start_radius[31]}}, src.start_radius};
    assign tq    = {{32{src.top_axis_height[31]}}, src.top_axis_height}
                 - {{32{src.bottom_axis_height[31]}}, src.bottom_axis_height};
    assign acirc = mag64(circ_reg);
    assign sum65 = {1'b0, tmp_reg} + {1'b0, mul_prod[63:0]};
    assign dtn   = ($signed(tmp_reg) < $signed(dt1_reg)) ? tmp_reg : dt1_reg;

    always_comb begin
        state_next     = state_reg;
        item_next      = item_reg;
        gain1_next     = gain1_reg;
        gain2_next     = gain2_reg;
        smooth_next    = smooth_reg;
        param_next     = param_reg;
        phys_next      = phys_reg;
        circ_next      = circ_reg;
        imp_next       = imp_reg;
        vol_next       = vol_reg;
        step_cnt_next  = step_cnt_reg;
        time_next      = time_reg;
        step_next      = step_reg;
        sat_next       = sat_reg;
        tmp_next       = tmp_reg;
        dt1_next       = dt1_reg;
        imp_out_next   = imp_out_reg;
        vol_out_next   = vol_out_reg;
        mul_start_next = 1'b0;
        mul_a_next     = mul_a_reg;
        mul_b_next     = mul_b_reg;
        ss_start_next  = 1'b0;
        ss_sqrt_next   = ss_sqrt_reg;
        ss_num_next    = ss_num_reg;
        ss_den_next    = ss_den_reg;
        out_next       = out_reg;
        m_valid_next   = m_valid_reg;
        res_a          = '0;
        res_b          = '0;
        res_c          = '0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        if (cfg_valid) begin
            case (cfg_index)
                REG_GAIN_ONE:  gain1_next  = cfg_data[30:0];
                REG_GAIN_TWO:  gain2_next  = cfg_data[30:0];
                REG_SMOOTHING: smooth_next = cfg_data[30:0];
                default: ;
            endcase
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next = s_data;
                    case (s_data.kind)
                        KIND_NODE: begin
                            mul_a_next     = mag64(g64);
                            mul_b_next     = mag64(w64);
                            mul_start_next = 1'b1;
                            state_next     = ST_N_GW;
                        end
                        KIND_SEG: begin
                            mul_a_next     = mag64(dr);
                            mul_b_next     = mag64(dr);
                            mul_start_next = 1'b1;
                            state_next     = ST_S_R2;
                        end
                        KIND_FIN: begin
                            res_a          = add_sat(time_reg, step_reg);
                            time_next      = res_a[63:0];
                            sat_next       = sat_reg | res_a[64];
                            step_cnt_next  = step_cnt_reg + 32'd1;
                            mul_a_next     = mag64(imp_reg);
                            mul_b_next     = TWO_PI_Q60;
                            mul_start_next = 1'b1;
                            state_next     = ST_F_IMP;
                        end
                        default: ;
                    endcase
                end
            end
            ST_N_GW: begin
                if (mul_done) begin
                    res_a          = sat_mag({64'd0, mul_prod[63:0]}, g64[63] ^ w64[63]);
                    tmp_next       = res_a[63:0];
                    res_b          = add_sat(circ_reg, res_a[63:0]);
                    circ_next      = res_b[63:0];
                    res_c          = add_sat(param_reg, w64 << FRAC_BITS);
                    param_next     = res_c[63:0];
                    sat_next       = sat_reg | res_b[64] | res_c[64];
                    mul_a_next     = mag64(r64);
                    mul_b_next     = mag64(r64);
                    mul_start_next = 1'b1;
                    state_next     = ST_N_RR;
                end
            end
            ST_N_RR: begin
                if (mul_done) begin
                    mul_a_next     = mag64(tmp_reg);
                    mul_b_next     = mul_prod[63:0];
                    mul_start_next = 1'b1;
                    state_next     = ST_N_IMP;
                end
            end
            ST_N_IMP: begin
                if (mul_done) begin
                    res_a      = sat_mag(mul_prod >> SH2, tmp_reg[63]);
                    res_b      = add_sat(imp_reg, res_a[63:0]);
                    imp_next   = res_b[63:0];
                    sat_next   = sat_reg | res_a[64] | res_b[64];
                    state_next = ST_IDLE;
                end
            end
            ST_S_R2: begin
                if (mul_done) begin
                    tmp_next       = mul_prod[63:0];
                    mul_a_next     = mag64(dz);
                    mul_b_next     = mag64(dz);
                    mul_start_next = 1'b1;
                    state_next     = ST_S_Z2;
                end
            end
            ST_S_Z2: begin
                if (mul_done) begin
                    ss_num_next   = {63'd0, sum65} << SH2;
                    ss_sqrt_next  = 1'b1;
                    ss_start_next = 1'b1;
                    state_next    = ST_S_SQ;
                end
            end
            ST_S_SQ: begin
                if (ss_done) begin
                    mul_a_next     = ss_result[63:0];
                    mul_b_next     = {60'd0, src.layer_count};
                    mul_start_next = 1'b1;
                    state_next     = ST_S_LEN;
                end
            end
            ST_S_LEN: begin
                if (mul_done) begin
                    res_a     = add_sat(phys_reg, mul_prod[63:0]);
                    phys_next = res_a[63:0];
                    sat_next  = sat_reg | res_a[64];
                    if (src.is_interfacial) begin
                        mul_a_next     = mag64(s_sum);
                        mul_b_next     = mag64(s_sum);
                        mul_start_next = 1'b1;
                        state_next     = ST_S_RM;
                    end else begin
                        state_next = ST_IDLE;
                    end
                end
            end
            ST_S_RM: begin
                if (mul_done) begin
                    // squared mean radius, always non-negative
                    res_a          = sat_mag(mul_prod >> 2, 1'b0);
                    sat_next       = sat_reg | res_a[64];
                    mul_a_next     = res_a[63:0];
                    mul_b_next     = mag64(dz);
                    mul_start_next = 1'b1;
                    state_next     = ST_S_VOL;
                end
            end
            ST_S_VOL: begin
                if (mul_done) begin
                    res_a      = sat_mag(mul_prod >> FRAC_BITS, dz[63]);
                    res_b      = add_sat(vol_reg, res_a[63:0]);
                    vol_next   = res_b[63:0];
                    sat_next   = sat_reg | res_a[64] | res_b[64];
                    state_next = ST_IDLE;
                end
            end
            ST_F_IMP: begin
                if (mul_done) begin
                    res_a          = sat_mag(mul_prod >> 60, imp_reg[63]);
                    imp_out_next   = res_a[63:0];
                    sat_next       = sat_reg | res_a[64];
                    mul_a_next     = mag64(vol_reg);
                    mul_b_next     = PI_Q60;
                    mul_start_next = 1'b1;
                    state_next     = ST_F_VOL;
                end
            end
            ST_F_VOL: begin
                if (mul_done) begin
                    res_a          = sat_mag(mul_prod >> 60, vol_reg[63]);
                    vol_out_next   = res_a[63:0];
                    sat_next       = sat_reg | res_a[64];
                    mul_a_next     = {33'd0, gain1_reg};
                    mul_b_next     = acirc;
                    mul_start_next = 1'b1;
                    state_next     = ST_F_M1;
                end
            end
            ST_F_M1: begin
                if (mul_done) begin
                    if (tq == 64'd0) begin
                        // zero thickness: limit is open
                        dt1_next       = S64_MAX;
                        sat_next       = 1'b1;
                        mul_a_next     = {33'd0, gain2_reg};
                        mul_b_next     = {33'd0, smooth_reg};
                        mul_start_next = 1'b1;
                        state_next     = ST_F_M2;
                    end else begin
                        ss_num_next   = mul_prod;
                        ss_den_next   = mag64(tq);
                        ss_sqrt_next  = 1'b0;
                        ss_start_next = 1'b1;
                        state_next    = ST_F_D1;
                    end
                end
            end
            ST_F_D1: begin
                if (ss_done) begin
                    res_a          = sat_mag(ss_result, tq[63]);
                    dt1_next       = res_a[63:0];
                    sat_next       = sat_reg | res_a[64];
                    mul_a_next     = {33'd0, gain2_reg};
                    mul_b_next     = {33'd0, smooth_reg};
                    mul_start_next = 1'b1;
                    state_next     = ST_F_M2;
                end
            end
            ST_F_M2: begin
                if (mul_done) begin
                    if (acirc == 64'd0) begin
                        tmp_next   = S64_MAX;
                        sat_next   = 1'b1;
                        state_next = ST_F_EMIT;
                    end else begin
                        ss_num_next   = mul_prod << SH2;
                        ss_den_next   = acirc;
                        ss_sqrt_next  = 1'b0;
                        ss_start_next = 1'b1;
                        state_next    = ST_F_D2;
                    end
                end
            end
            ST_F_D2: begin
                if (ss_done) begin
                    res_a      = sat_mag(ss_result, 1'b0);
                    tmp_next   = res_a[63:0];
                    sat_next   = sat_reg | res_a[64];
                    state_next = ST_F_EMIT;
                end
            end
            ST_F_EMIT: begin
                if (!m_valid_reg || m_ready) begin
                    step_next              = dtn;
                    out_next.step_number   = step_cnt_reg;
                    out_next.sim_time      = time_reg;
                    out_next.next_step_size = dtn;
                    out_next.param_length  = param_reg;
                    out_next.phys_length   = phys_reg;
                    out_next.circ_total    = circ_reg;
                    out_next.impulse_total = imp_out_reg;
                    out_next.volume_total  = vol_out_reg;
                    out_next.thickness     = tq << FRAC_BITS;
                    out_next.saturated     = sat_reg;
                    m_valid_next           = 1'b1;
                    param_next             = '0;
                    phys_next              = '0;
                    circ_next              = '0;
                    imp_next               = '0;
                    vol_next               = '0;
                    sat_next               = 1'b0;
                    state_next             = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            gain1_reg     <= 31'd6554;
            gain2_reg     <= 31'd6554;
            smooth_reg    <= 31'd6554;
            param_reg     <= '0;
            phys_reg      <= '0;
            circ_reg      <= '0;
            imp_reg       <= '0;
            vol_reg       <= '0;
            step_cnt_reg  <= '0;
            time_reg      <= '0;
            step_reg      <= '0;
            sat_reg       <= 1'b0;
            mul_start_reg <= 1'b0;
            ss_start_reg  <= 1'b0;
            m_valid_reg   <= 1'b0;
        end else begin
            state_reg     <= state_next;
            gain1_reg     <= gain1_next;
            gain2_reg     <= gain2_next;
            smooth_reg    <= smooth_next;
            param_reg     <= param_next;
            phys_reg      <= phys_next;
            circ_reg      <= circ_next;
            imp_reg       <= imp_next;
            vol_reg       <= vol_next;
            step_cnt_reg  <= step_cnt_next;
            time_reg      <= time_next;
            step_reg      <= step_next;
            sat_reg       <= sat_next;
            mul_start_reg <= mul_start_next;
            ss_start_reg  <= ss_start_next;
            m_valid_reg   <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        tmp_reg     <= tmp_next;
        dt1_reg     <= dt1_next;
        imp_out_reg <= imp_out_next;
        vol_out_reg <= vol_out_next;
        mul_a_reg   <= mul_a_next;
        mul_b_reg   <= mul_b_next;
        ss_sqrt_reg <= ss_sqrt_next;
        ss_num_reg  <= ss_num_next;
        ss_den_reg  <= ss_den_next;
        out_reg     <= out_next;
    end

    assign s_ready   = (state_reg == ST_IDLE);
    assign m_valid   = m_valid_reg;
    assign m_data    = out_reg;
    assign cfg_ready = 1'b1;
endmodule

FILE: tb/vortex_sheet_integrals_checker.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vortex_sheet_integrals_checker
// Watches the input, result and register channels of the vortex sheet
// integrals unit, predicts every result word in fixed point and compares it
// field by field with the word that the unit sends.
// ----------------------------------------------------------------------------
module vortex_sheet_integrals_checker (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               s_valid,
    input  logic               s_ready,
    input  vsi_pkg::in_word_t  s_data,
    input  logic               m_valid,
    input  logic               m_ready,
    input  vsi_pkg::out_word_t m_data,
    input  logic               cfg_valid,
    input  logic               cfg_ready,
    input  logic [1:0]         cfg_index,
    input  logic [31:0]        cfg_data,
    output int                 fail_count,
    output int                 pending_count
);
    import vsi_pkg::*;

    localparam int F = 16;

    logic [63:0] k_one, k_two, k_smooth;
    logic signed [63:0] sum_param, sum_phys, sum_circ, sum_impulse, sum_volume;
    logic [31:0] steps_done;
    logic signed [63:0] clock_time, step_len;
    logic sticky_sat;
    out_word_t integrals_q[$];

    function automatic logic [63:0] magnitude(input logic signed [63:0] a);
        return a[63] ? 64'd0 - a : a;
    endfunction

    function automatic logic signed [63:0] sat_sum(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [63:0] s;
        s = a + b;
        if (a[63] == b[63] && s[63] != a[63]) begin
            sticky_sat = 1'b1;
            return a[63] ? S64_MIN : S64_MAX;
        end
        return s;
    endfunction

    // product magnitude shifted down, sign applied, saturated
    function automatic logic signed [63:0] scaled_product(input logic signed [63:0] a,
                                                          input logic signed [63:0] b,
                                                          input int sh);
        logic [127:0] p;
        logic neg;
        logic [63:0] lim;
        neg = a[63] ^ b[63];
        p = {64'd0, magnitude(a)} * {64'd0, magnitude(b)};
        p = p >> sh;
        lim = neg ? S64_MIN : S64_MAX;
        if (p[127:64] != 0 || p[63:0] > lim) begin
            sticky_sat = 1'b1;
            return lim;
        end
        return neg ? 64'd0 - p[63:0] : p[63:0];
    endfunction

    function automatic logic [63:0] floor_root(input logic [127:0] v);
        logic [63:0] r, c;
        logic [127:0] sq;
        r = 0;
        for (int b = 63; b >= 0; b--) begin
            c = r | (64'd1 << b);
            sq = {64'd0, c} * {64'd0, c};
            if (sq <= v) r = c;
        end
        return r;
    endfunction

    function automatic logic [63:0] bounded_quotient(input logic [127:0] n,
                                                     input logic [63:0] d,
                                                     input logic [63:0] lim);
        logic [127:0] q;
        q = n / {64'd0, d};
        if (q[127:64] != 0 || q[63:0] > lim) begin
            sticky_sat = 1'b1;
            return lim;
        end
        return q[63:0];
    endfunction

    task automatic clear_sums();
        sum_param = 0;
        sum_phys = 0;
        sum_circ = 0;
        sum_impulse = 0;
        sum_volume = 0;
        sticky_sat = 1'b0;
    endtask

    task automatic absorb_word(input in_word_t w);
        logic signed [63:0] g, wt, r, gw, sr, sz, er, ez, dr, dz, s, rm2, tq;
        logic signed [63:0] imp, vol, dt1, dt2;
        logic [127:0] len2;
        logic [63:0] acirc, p, len;
        out_word_t res;
        case (w.kind)
            KIND_NODE: begin
                g = w.node_strength;
                wt = w.node_weight;
                r = w.node_radius;
                gw = g * wt;
                sum_param = sat_sum(sum_param, wt <<< F);
                sum_circ = sat_sum(sum_circ, gw);
                sum_impulse = sat_sum(sum_impulse, scaled_product(gw, r * r, 2 * F));
            end
            KIND_SEG: begin
                sr = w.start_radius;
                sz = w.start_height;
                er = w.end_radius;
                ez = w.end_height;
                dr = er - sr;
                dz = ez - sz;
                len2 = ({64'd0, magnitude(dr)} * magnitude(dr)
                        + {64'd0, magnitude(dz)} * magnitude(dz)) << (2 * F);
                len = floor_root(len2);
                sum_phys = sat_sum(sum_phys, len * w.layer_count);
                if (w.is_interfacial) begin
                    s = sr + er;
                    rm2 = scaled_product(s, s, 2);
                    sum_volume = sat_sum(sum_volume, scaled_product(rm2, dz, F));
                end
            end
            KIND_FIN: begin
                tq = 64'(w.top_axis_height) - 64'(w.bottom_axis_height);
                imp = scaled_product(sum_impulse, TWO_PI_Q60, 60);
                vol = scaled_product(sum_volume, PI_Q60, 60);
                acirc = magnitude(sum_circ);
                clock_time = sat_sum(clock_time, step_len);
                steps_done = steps_done + 32'd1;
                if (tq == 0) begin
                    sticky_sat = 1'b1;
                    dt1 = S64_MAX;
                end else begin
                    p = bounded_quotient({64'd0, k_one} * acirc, magnitude(tq),
                                         tq[63] ? S64_MIN : S64_MAX);
                    dt1 = tq[63] ? 64'd0 - p : p;
                end
                if (acirc == 0) begin
                    sticky_sat = 1'b1;
                    dt2 = S64_MAX;
                end else begin
                    p = k_two * k_smooth;
                    dt2 = bounded_quotient({64'd0, p} << (2 * F), acirc, S64_MAX);
                end
                step_len = dt2 < dt1 ? dt2 : dt1;
                res.step_number = steps_done;
                res.sim_time = clock_time;
                res.next_step_size = step_len;
                res.param_length = sum_param;
                res.phys_length = sum_phys;
                res.circ_total = sum_circ;
                res.impulse_total = imp;
                res.volume_total = vol;
                res.thickness = tq <<< F;
                res.saturated = sticky_sat;
                integrals_q.push_back(res);
                clear_sums();
            end
            default: ;
        endcase
    endtask

    task automatic report(input string what, input logic [63:0] got,
                          input logic [63:0] want);
        $display("mismatch %s: got %h want %h at %0t", what, got, want, $realtime);
        fail_count++;
    endtask

    task automatic compare_word(input out_word_t got);
        out_word_t w;
        if (integrals_q.size() == 0) begin
            report("unexpected word", 0, 0);
            return;
        end
        w = integrals_q.pop_front();
        if (got.step_number !== w.step_number) report("step_number", got.step_number, w.step_number);
        if (got.sim_time !== w.sim_time) report("sim_time", got.sim_time, w.sim_time);
        if (got.next_step_size !== w.next_step_size)
            report("next_step_size", got.next_step_size, w.next_step_size);
        if (got.param_length !== w.param_length)
            report("param_length", got.param_length, w.param_length);
        if (got.phys_length !== w.phys_length)
            report("phys_length", got.phys_length, w.phys_length);
        if (got.circ_total !== w.circ_total) report("circ_total", got.circ_total, w.circ_total);
        if (got.impulse_total !== w.impulse_total)
            report("impulse_total", got.impulse_total, w.impulse_total);
        if (got.volume_total !== w.volume_total)
            report("volume_total", got.volume_total, w.volume_total);
        if (got.thickness !== w.thickness) report("thickness", got.thickness, w.thickness);
        if (got.saturated !== w.saturated) report("saturated", got.saturated, w.saturated);
    endtask

    initial begin
        fail_count = 0;
        pending_count = 0;
    end

    always @(posedge aclk) begin
        if (!aresetn) begin
            k_one = 6554;
            k_two = 6554;
            k_smooth = 6554;
            clear_sums();
            steps_done = 0;
            clock_time = 0;
            step_len = 0;
            integrals_q.delete();
        end else begin
            if (m_valid && m_ready) compare_word(m_data);
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    REG_GAIN_ONE:  k_one = {33'd0, cfg_data[30:0]};
                    REG_GAIN_TWO:  k_two = {33'd0, cfg_data[30:0]};
                    REG_SMOOTHING: k_smooth = {33'd0, cfg_data[30:0]};
                    default: ;
                endcase
            end
            if (s_valid && s_ready) absorb_word(s_data);
        end
        pending_count = integrals_q.size();
    end

endmodule

FILE: tb/vortex_sheet_integrals_unit_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// vortex_sheet_integrals_unit_test
// Drives node, segment and finish words with random gaps and result stalls
// through several register settings; the checker predicts and compares.
// ----------------------------------------------------------------------------
module vortex_sheet_integrals_unit_test;
    import vsi_pkg::*;

    logic aclk = 1'b0;
    logic aresetn = 1'b0;
    logic s_valid = 1'b0;
    logic s_ready;
    in_word_t s_data = '0;
    logic m_valid;
    logic m_ready = 1'b0;
    out_word_t m_data;
    logic cfg_valid = 1'b0;
    logic cfg_ready;
    logic [1:0] cfg_index = REG_GAIN_ONE;
    logic [31:0] cfg_data = '0;
    int fail_count;
    int pending_count;
    int cycle_count = 0;
    bit stall_on = 1'b1;

    always #5 aclk = ~aclk;

    vortex_sheet_integrals_unit dut (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data)
    );

    vortex_sheet_integrals_checker checker_i (
        .aclk(aclk), .aresetn(aresetn),
        .s_valid(s_valid), .s_ready(s_ready), .s_data(s_data),
        .m_valid(m_valid), .m_ready(m_ready), .m_data(m_data),
        .cfg_valid(cfg_valid), .cfg_ready(cfg_ready),
        .cfg_index(cfg_index), .cfg_data(cfg_data),
        .fail_count(fail_count), .pending_count(pending_count)
    );

    function automatic int gap_len();
        if ($urandom_range(0, 9) == 0) return $urandom_range(10, 60);
        return $urandom_range(0, 3);
    endfunction

    always @(posedge aclk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > 3000000) begin
            $display("TEST FAILED");
            $finish;
        end
    end

    // result side back-pressure
    initial begin
        forever begin
            @(negedge aclk);
            if (stall_on && $urandom_range(0, 3) == 0) begin
                m_ready <= 1'b0;
                repeat (gap_len() + 1) @(negedge aclk);
            end
            m_ready <= 1'b1;
        end
    end

    task automatic send_word(input in_word_t w);
        @(negedge aclk);
        repeat (gap_len()) @(negedge aclk);
        s_data <= w;
        s_valid <= 1'b1;
        @(posedge aclk);
        while (!s_ready) @(posedge aclk);
        @(negedge aclk);
        s_valid <= 1'b0;
    endtask

    task automatic write_reg(input logic [1:0] idx, input logic [31:0] v);
        @(negedge aclk);
        cfg_index <= idx;
        cfg_data <= v;
        cfg_valid <= 1'b1;
        @(posedge aclk);
        while (!cfg_ready) @(posedge aclk);
        @(negedge aclk);
        cfg_valid <= 1'b0;
    endtask

    task automatic drain();
        while (pending_count != 0) @(posedge aclk);
        repeat (400) @(posedge aclk);
    endtask

    function automatic logic [31:0] rand_q(input int mode);
        case (mode)
            0: return $urandom();
            1: return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
            2: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
            default: return $urandom_range(0, 32'h0000_4000) - 32'h0000_2000;
        endcase
    endfunction

    function automatic in_word_t rand_word(input logic [1:0] k);
        in_word_t w;
        int mode;
        mode = $urandom_range(0, 9) == 0 ? $urandom_range(0, 2) : $urandom_range(1, 3);
        w.kind = k;
        w.node_strength = rand_q(mode);
        w.node_weight = rand_q(mode);
        w.node_radius = rand_q(mode);
        w.start_radius = rand_q(mode);
        w.start_height = rand_q(mode);
        w.end_radius = rand_q(mode);
        w.end_height = rand_q(mode);
        w.layer_count = 4'($urandom_range(0, 15));
        w.is_interfacial = 1'($urandom_range(0, 1));
        w.top_axis_height = rand_q(mode);
        w.bottom_axis_height = $urandom_range(0, 7) == 0 ? w.top_axis_height : rand_q(mode);
        return w;
    endfunction

    task automatic directed_part();
        in_word_t w;
        w = '0;
        w.kind = KIND_FIN;
        send_word(w);                                  // zero circ and zero thickness
        w = rand_word(KIND_NODE);
        w.node_strength = 32'h7FFF_FFFF;
        w.node_weight = 32'h8000_0000;
        w.node_radius = 32'h7FFF_FFFF;
        send_word(w);
        send_word(w);                                  // sums overflow
        w = rand_word(KIND_SEG);
        w.start_radius = 32'h8000_0000;
        w.end_radius = 32'h7FFF_FFFF;
        w.start_height = 32'h8000_0000;
        w.end_height = 32'h7FFF_FFFF;
        w.layer_count = 4'hF;
        w.is_interfacial = 1'b1;
        send_word(w);
        w = rand_word(KIND_FIN);
        w.top_axis_height = 32'h8000_0000;
        w.bottom_axis_height = 32'h7FFF_FFFF;          // negative thickness
        send_word(w);
        w = rand_word(KIND_NODE);
        send_word(w);
        w = '1;                                        // unused kind, ignored
        send_word(w);
        w = rand_word(KIND_SEG);
        w.is_interfacial = 1'b0;
        send_word(w);
        w = rand_word(KIND_FIN);
        w.top_axis_height = 32'h7FFF_FFFF;
        w.bottom_axis_height = 32'h8000_0000;
        send_word(w);
        w = '0;
        w.kind = KIND_NODE;
        w.node_strength = 32'h0000_0001;
        w.node_weight = 32'h0000_0001;
        send_word(w);
        w = '0;
        w.kind = KIND_FIN;
        w.top_axis_height = 32'h0000_0001;             // huge quotients
        send_word(w);
        drain();
    endtask

    task automatic random_pass(input int n);
        in_word_t w;
        int r;
        for (int i = 0; i < n; i++) begin
            r = $urandom_range(0, 19);
            if (r == 0) begin
                w = rand_word(KIND_NODE);
                w.kind = 2'd3;
            end else if (r < 4) w = rand_word(KIND_FIN);
            else if (r < 12) w = rand_word(KIND_NODE);
            else w = rand_word(KIND_SEG);
            send_word(w);
        end
        send_word(rand_word(KIND_FIN));
    endtask

    initial begin
        repeat (11) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;
        directed_part();
        for (int phase = 0; phase < 5; phase++) begin
            case (phase)
                0: begin
                    write_reg(REG_GAIN_ONE, 32'hFFFF_FFFF);
                    write_reg(REG_GAIN_TWO, 32'h7FFF_FFFF);
                    write_reg(REG_SMOOTHING, 32'h7FFF_FFFF);
                end
                1: begin
                    write_reg(REG_GAIN_ONE, 32'd0);
                    write_reg(REG_GAIN_TWO, 32'd0);
                    write_reg(REG_SMOOTHING, 32'd0);
                end
                2: stall_on = 1'b0;
                default: begin
                    stall_on = 1'b1;
                    write_reg(REG_GAIN_ONE, $urandom());
                    write_reg(REG_GAIN_TWO, $urandom_range(0, 32'h0002_0000));
                    write_reg(REG_SMOOTHING, $urandom_range(0, 32'h0002_0000));
                end
            endcase
            random_pass(105);
            drain();
        end
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
